>>> rtl/core/uhb_pkg.sv
// uhb_pkg: shared types and constants for the ustar header builder.
// Used by uhb_front, uhb_queue, uhb_back and the top level.
package uhb_pkg;

  localparam int unsigned IN_TDATA_W  = 216;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TUSER_W = 6;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam int unsigned PATH_ROWS  = 13;
  localparam int unsigned NAME_ROWS  = 4;
  localparam int unsigned PATH_RA_W  = 4;
  localparam int unsigned NAME_RA_W  = 2;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = 1;
  localparam int unsigned QCNT_W     = 2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_BUILD = 1'b1;

  localparam logic [1:0] SEL_PATH  = 2'd0;
  localparam logic [1:0] SEL_USER  = 2'd1;
  localparam logic [1:0] SEL_GROUP = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_MTIME = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FMODE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DMODE = 2'd2;

  localparam logic [31:0] RST_MTIME = 32'd1700000000;
  localparam logic [11:0] RST_FMODE = 12'o0644;
  localparam logic [11:0] RST_DMODE = 12'o0755;

  // word positions inside the 512-byte header
  localparam logic [5:0] W_PATH_LAST  = 6'd12;
  localparam logic [5:0] W_LEAD_LAST  = 6'd17;
  localparam logic [5:0] W_CHKSUM     = 6'd18;
  localparam logic [5:0] W_TYPE       = 6'd19;
  localparam logic [5:0] W_MAGIC      = 6'd32;
  localparam logic [5:0] W_USER       = 6'd33;
  localparam logic [5:0] W_USER_LAST  = 6'd36;
  localparam logic [5:0] W_GROUP      = 6'd37;
  localparam logic [5:0] W_GROUP_LAST = 6'd40;
  localparam logic [5:0] W_GROUP_END  = 6'd41;
  localparam logic [5:0] W_LAST       = 6'd63;

  // byte 0 in bits 7:0
  localparam logic [63:0] NAME_UNNAMED = 64'h0064_656D_616E_6E75;
  localparam logic [63:0] NAME_STAFF   = 64'h0000_0066_6661_7473;
  localparam logic [63:0] MAGIC_WORD   = 64'h3000_7261_7473_7500;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DIR   = 8'h35;
  localparam logic [7:0] CH_FILE  = 8'h30;

  typedef struct packed {
    logic        build;
    logic [1:0]  sel;
    logic [3:0]  chunk;
    logic [63:0] bytes;
    logic [11:0] mode;
    logic [20:0] uid;
    logic [20:0] gid;
    logic [32:0] fsize;
    logic [31:0] mtime;
    logic        dir;
    logic [2:0]  given;
  } item_t;

  function automatic logic [7:0] octal_char(input logic [2:0] d);
    return {5'b00110, d};
  endfunction

endpackage

>>> rtl/core/uhb_front.sv
// uhb_front: input word decode, default resolution and configuration registers.
// Depends on uhb_pkg; feeds uhb_queue.
module uhb_front import uhb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [IN_TUSER_W-1:0] in_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  q_push,
  output item_t                 q_item,
  input  logic                  q_ready
);

  logic [31:0] dmtime_r;
  logic [11:0] fmode_r;
  logic [11:0] dmode_r;

  logic [31:0] mode_bits;
  logic [31:0] mod_time;
  logic        is_dir;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dmtime_r <= RST_MTIME;
      fmode_r  <= RST_FMODE;
      dmode_r  <= RST_DMODE;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MTIME: dmtime_r <= cfg_wdata;
        REG_FMODE: fmode_r  <= cfg_wdata[11:0];
        REG_DMODE: dmode_r  <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  assign mode_bits = in_tdata[99:68];
  assign mod_time  = in_tdata[206:175];
  assign is_dir    = in_tdata[207];

  assign in_tready = q_ready;
  assign q_push    = in_tvalid && q_ready;

  always_comb begin
    q_item.build = in_tuser[0];
    q_item.sel   = in_tuser[2:1];
    q_item.chunk = in_tdata[3:0];
    q_item.bytes = in_tdata[67:4];
    q_item.mode  = (mode_bits != '0) ? mode_bits[11:0] : (is_dir ? dmode_r : fmode_r);
    q_item.uid   = in_tdata[120:100];
    q_item.gid   = in_tdata[141:121];
    q_item.fsize = is_dir ? '0 : in_tdata[174:142];
    q_item.mtime = (mod_time != '0) ? mod_time : dmtime_r;
    q_item.dir   = is_dir;
    q_item.given = in_tdata[210:208];
  end

endmodule

>>> rtl/core/uhb_queue.sv
// uhb_queue: two-entry queue of decoded items between front and back.
// Depends on uhb_pkg.
module uhb_queue import uhb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  ready,
  input  logic  pop,
  output logic  valid,
  output item_t head
);

  item_t             ent_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign ready   = cnt_r != QCNT_W'(QDEPTH);
  assign valid   = cnt_r != '0;
  assign head    = ent_r[rptr_r];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop) rptr_r <= rptr_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/uhb_back.sv
// uhb_back: name stores, header word sequencer, checksum and output register.
// Depends on uhb_pkg; takes items from uhb_queue.
module uhb_back import uhb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic [5:0]  out_tuser,
  output logic        out_tlast
);

  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_SUM  = 2'd1;
  localparam logic [1:0] PH_EMIT = 2'd2;

  localparam logic [1:0] CL_NONE  = 2'd0;
  localparam logic [1:0] CL_PATH  = 2'd1;
  localparam logic [1:0] CL_USER  = 2'd2;
  localparam logic [1:0] CL_GROUP = 2'd3;

  logic [63:0] path_mem_r  [PATH_ROWS];
  logic [63:0] user_mem_r  [NAME_ROWS];
  logic [63:0] group_mem_r [NAME_ROWS];
  logic [PATH_ROWS-1:0] path_vld_r;
  logic [NAME_ROWS-1:0] user_vld_r;
  logic [NAME_ROWS-1:0] group_vld_r;

  logic        busy_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [5:0]  k_r, k_nxt;
  item_t       cur_r;

  logic        b_valid_r;
  logic [1:0]  b_phase_r;
  logic [5:0]  b_k_r;
  logic [63:0] path_q_r, user_q_r, group_q_r;
  logic        path_vq_r, user_vq_r, group_vq_r;
  logic [7:0]  carry_r;
  logic        path_end_r, user_end_r, group_end_r;
  logic [16:0] sum_r;

  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic [5:0]  out_idx_r;
  logic        out_last_r;

  logic adv, step, last_step, load_we, build_go;
  logic path_we, user_we, group_we, path_re, user_re, group_re;
  logic [PATH_RA_W-1:0] path_ra;
  logic [NAME_RA_W-1:0] user_ra, group_ra;

  logic [63:0] path_row, user_row, group_row;
  logic [7:0]  rg [64];
  logic [7:0]  wb [8];
  logic [1:0]  cls [8];
  logic [5:0]  ridx;
  logic [20:0] mode21;
  logic [32:0] mt33;
  logic [17:0] sum18;
  logic        pe, ue, ge;
  logic [10:0] bsum;
  logic [63:0] word;

  assign adv       = !out_valid_r || out_tready;
  assign q_pop     = q_valid && !busy_r;
  assign load_we   = q_pop && (q_item.build == CMD_LOAD);
  assign build_go  = q_pop && (q_item.build == CMD_BUILD);
  assign step      = busy_r && adv;
  assign last_step = (phase_r == PH_EMIT) && (k_r == W_LAST);

  assign path_we  = load_we && (q_item.sel == SEL_PATH) && (q_item.chunk < 4'(PATH_ROWS));
  assign user_we  = load_we && (q_item.sel == SEL_USER) && (q_item.chunk < 4'(NAME_ROWS));
  assign group_we = load_we && (q_item.sel == SEL_GROUP) && (q_item.chunk < 4'(NAME_ROWS));

  assign path_ra  = k_r[PATH_RA_W-1:0];
  assign user_ra  = NAME_RA_W'(k_r - W_USER);
  assign group_ra = NAME_RA_W'(k_r - W_GROUP);
  assign path_re  = step && (k_r <= W_PATH_LAST);
  assign user_re  = step && (k_r >= W_USER) && (k_r <= W_USER_LAST);
  assign group_re = step && (k_r >= W_GROUP) && (k_r <= W_GROUP_LAST);

  // step order: lead words 0..17, checksum-only 18,19,32..41, then emit 18..63
  always_comb begin
    phase_nxt = phase_r;
    k_nxt     = k_r + 6'd1;
    unique case (phase_r)
      PH_LEAD: begin
        if (k_r == W_LEAD_LAST) phase_nxt = PH_SUM;
      end
      PH_SUM: begin
        if (k_r == W_TYPE) begin
          k_nxt = W_MAGIC;
        end else if (k_r == W_GROUP_END) begin
          phase_nxt = PH_EMIT;
          k_nxt     = W_CHKSUM;
        end
      end
      PH_EMIT: ;
      default: phase_nxt = PH_LEAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (path_we) path_mem_r[q_item.chunk] <= q_item.bytes;
    if (user_we) user_mem_r[q_item.chunk[NAME_RA_W-1:0]] <= q_item.bytes;
    if (group_we) group_mem_r[q_item.chunk[NAME_RA_W-1:0]] <= q_item.bytes;
    if (path_re) begin
      path_q_r  <= path_mem_r[path_ra];
      path_vq_r <= path_vld_r[path_ra];
    end
    if (user_re) begin
      user_q_r  <= user_mem_r[user_ra];
      user_vq_r <= user_vld_r[user_ra];
    end
    if (group_re) begin
      group_q_r  <= group_mem_r[group_ra];
      group_vq_r <= group_vld_r[group_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_vld_r  <= '0;
      user_vld_r  <= '0;
      group_vld_r <= '0;
    end else if (step && last_step) begin
      path_vld_r  <= '0;
      user_vld_r  <= '0;
      group_vld_r <= '0;
    end else begin
      if (path_we) path_vld_r[q_item.chunk] <= 1'b1;
      if (user_we) user_vld_r[q_item.chunk[NAME_RA_W-1:0]] <= 1'b1;
      if (group_we) group_vld_r[q_item.chunk[NAME_RA_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= PH_LEAD;
      k_r         <= '0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (build_go) begin
        busy_r  <= 1'b1;
        phase_r <= PH_LEAD;
        k_r     <= '0;
      end else if (step) begin
        if (last_step) busy_r <= 1'b0;
        phase_r <= phase_nxt;
        k_r     <= k_nxt;
      end
      if (adv) begin
        b_valid_r   <= busy_r;
        out_valid_r <= b_valid_r && (b_phase_r != PH_SUM);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (build_go) cur_r <= q_item;
    if (adv) begin
      b_phase_r  <= phase_r;
      b_k_r      <= k_r;
      out_data_r <= word;
      out_idx_r  <= b_k_r;
      out_last_r <= b_k_r == W_LAST;
    end
    if (adv && b_valid_r) begin
      path_end_r  <= pe;
      user_end_r  <= ue;
      group_end_r <= ge;
      if (b_k_r >= W_USER && b_k_r <= W_GROUP_LAST) begin
        carry_r <= (b_k_r <= W_USER_LAST) ? user_row[63:56] : group_row[63:56];
      end
    end
    if (build_go) begin
      sum_r <= '0;
    end else if (adv && b_valid_r && b_phase_r != PH_EMIT) begin
      sum_r <= sum_r + 17'(bsum);
    end
  end

  // fixed-format fields, header bytes 96..159
  always_comb begin
    mode21 = {9'd0, cur_r.mode};
    mt33   = {1'b0, cur_r.mtime};
    sum18  = {1'b0, sum_r};
    for (int i = 0; i < 64; i++) rg[i] = '0;
    for (int i = 0; i < 7; i++) begin
      rg[4 + i]  = octal_char(mode21[3*(6-i) +: 3]);
      rg[12 + i] = octal_char(cur_r.uid[3*(6-i) +: 3]);
      rg[20 + i] = octal_char(cur_r.gid[3*(6-i) +: 3]);
    end
    for (int i = 0; i < 11; i++) begin
      rg[28 + i] = octal_char(cur_r.fsize[3*(10-i) +: 3]);
      rg[40 + i] = octal_char(mt33[3*(10-i) +: 3]);
    end
    if (b_phase_r == PH_EMIT) begin
      for (int i = 0; i < 6; i++) rg[52 + i] = octal_char(sum18[3*(5-i) +: 3]);
      rg[59] = CH_SPACE;
    end else begin
      for (int i = 0; i < 8; i++) rg[52 + i] = CH_SPACE;
    end
    rg[60] = cur_r.dir ? CH_DIR : CH_FILE;
  end

  always_comb begin
    path_row  = cur_r.given[0] ? (path_vq_r ? path_q_r : '0)
                               : ((b_k_r == '0) ? NAME_UNNAMED : '0);
    user_row  = cur_r.given[1] ? (user_vq_r ? user_q_r : '0)
                               : ((b_k_r == W_USER) ? NAME_STAFF : '0);
    group_row = cur_r.given[2] ? (group_vq_r ? group_q_r : '0)
                               : ((b_k_r == W_GROUP) ? NAME_STAFF : '0);
    ridx = b_k_r - W_PATH_LAST;
    for (int i = 0; i < 8; i++) begin
      wb[i]  = '0;
      cls[i] = CL_NONE;
    end
    if (b_k_r < W_PATH_LAST) begin
      for (int i = 0; i < 8; i++) begin
        wb[i]  = path_row[8*i +: 8];
        cls[i] = CL_PATH;
      end
    end else if (b_k_r == W_PATH_LAST) begin
      for (int i = 0; i < 4; i++) begin
        wb[i]  = path_row[8*i +: 8];
        cls[i] = CL_PATH;
      end
      for (int i = 4; i < 8; i++) wb[i] = rg[{ridx[2:0], 3'(i)}];
    end else if (b_k_r <= W_TYPE) begin
      for (int i = 0; i < 8; i++) wb[i] = rg[{ridx[2:0], 3'(i)}];
    end else if (b_k_r == W_MAGIC) begin
      for (int i = 0; i < 8; i++) wb[i] = MAGIC_WORD[8*i +: 8];
    end else if (b_k_r >= W_USER && b_k_r <= W_GROUP_LAST) begin
      if (b_k_r == W_USER) begin
        wb[0] = CH_ZERO;
      end else begin
        wb[0]  = carry_r;
        cls[0] = (b_k_r <= W_GROUP) ? CL_USER : CL_GROUP;
      end
      for (int i = 1; i < 8; i++) begin
        wb[i]  = (b_k_r <= W_USER_LAST) ? user_row[8*(i-1) +: 8] : group_row[8*(i-1) +: 8];
        cls[i] = (b_k_r <= W_USER_LAST) ? CL_USER : CL_GROUP;
      end
    end else if (b_k_r == W_GROUP_END) begin
      wb[0]  = carry_r;
      cls[0] = CL_GROUP;
    end

    // names stop at their first NUL
    pe = (b_k_r == '0) ? 1'b0 : path_end_r;
    ue = (b_k_r == W_USER) ? 1'b0 : user_end_r;
    ge = (b_k_r == W_GROUP) ? 1'b0 : group_end_r;
    for (int i = 0; i < 8; i++) begin
      case (cls[i])
        CL_PATH: begin
          if (wb[i] == '0) pe = 1'b1;
          if (pe) wb[i] = '0;
        end
        CL_USER: begin
          if (wb[i] == '0) ue = 1'b1;
          if (ue) wb[i] = '0;
        end
        CL_GROUP: begin
          if (wb[i] == '0) ge = 1'b1;
          if (ge) wb[i] = '0;
        end
        default: ;
      endcase
    end

    bsum = '0;
    for (int i = 0; i < 8; i++) begin
      bsum      = bsum + 11'(wb[i]);
      word[8*i +: 8] = wb[i];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_idx_r;
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/core/ustar_header_builder.sv
// ustar_header_builder: top level of the tar ustar header builder.
// Depends on uhb_pkg, uhb_front, uhb_queue and uhb_back.
//
// Input channel (in_*): load words (tuser cmd = 0) write eight name bytes into
// the path, user or group store at the given chunk; build words (cmd = 1)
// carry the numeric metadata and emit one header.
// Output channel (out_*): each header leaves as 64 words of eight bytes,
// tuser = word index, tlast on word 63.
// Config port: cfg_we with cfg_addr 0 default mtime, 1 default file mode,
// 2 default directory mode; write only while idle.
// The first header word of a build passes the queue, the sequencer, the store
// read and the output register. Throughput: the back end pops a load only while
// idle; a build keeps it busy for 76 sequencer steps: 18 words emitted while
// summing, 12 words summed only for the checksum, then 46 words emitted, one
// step per cycle unless the receiver stalls, via the registered store read.
// A two-entry queue between decode and back end takes up to two words while
// a header is still streaming. When the receiver stalls, the sequencer and the
// store read freeze and the output word holds.
// Reset clears the queue, name store valid bits and output; registers take defaults.
module ustar_header_builder import uhb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // chunk_index, chunk_bytes, mode_bits, owner_id, group_id, size_bytes,
  // mod_time, dir_flag, given_mask, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd, string_select
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // word_data
  output logic [63:0]            out_tdata,
  // word_index
  output logic [OUT_TUSER_W-1:0] out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic  q_push, q_ready, q_pop, q_valid;
  item_t q_in, q_head;

  uhb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .q_push    (q_push),
    .q_item    (q_in),
    .q_ready   (q_ready)
  );

  uhb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  uhb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> rtl/core/uhb_checker.sv
// uhb_checker: port-level checks on the header output stream.
// Bound to ustar_header_builder; depends on nothing else.
module uhb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [5:0]  out_tuser,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("output word changed while stalled");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == 6'd63)))
    else $error("tlast does not match word 63");

  a_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      !out_tvalid || (out_tuser == $past(out_tuser) + 6'd1))
    else $error("word index skipped");

  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid || (out_tuser == 6'd0))
    else $error("header did not start at word 0");

  a_chksum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == 6'd19) |->
      (out_tdata[23:16] == 8'h00) && (out_tdata[31:24] == 8'h20))
    else $error("checksum field not closed by NUL and space");

endmodule

bind ustar_header_builder uhb_checker u_uhb_checker (.*);
